>>> src/ulojs_pkg.sv
// ============================================================================
// ulojs_pkg - shared types and constants for the datagram statistics unit
// Widths of the header fields and internal time values, and the transaction
// type that passes from the classifying front end to the statistics back end.
// ============================================================================
`timescale 1ns / 1ps

package ulojs_pkg;

  localparam int SEC_W  = 32;
  localparam int USEC_W = 20;
  localparam int SEQ_W  = 64;
  localparam int TIME_W = 53;
  localparam int JIT_W  = 57;
  localparam int JOUT_W = 56;
  localparam int CNT_W  = 64;

  localparam logic [TIME_W-1:0] USEC_PER_SEC = TIME_W'(1000000);

  localparam int DEFAULT_QUEUE_DEPTH = 4;

  // APB register map: word index taken from paddr[2]
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_COUNTER_64BIT = 1'b0;

  // One classified datagram, ready for the state update
  typedef struct packed {
    logic              running;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  seq_plus1;
    logic [TIME_W-1:0] transit_delta;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } queue_push_t;

endpackage

>>> src/ulojs_front.sv
// ============================================================================
// ulojs_front - two-stage classifier for incoming datagram headers
// Converts timestamps to microseconds, forms the transit time and its change
// against the previous running datagram, and pushes the result to the queue.
// ============================================================================
`timescale 1ns / 1ps

module ulojs_front #(
  parameter int QUEUE_DEPTH = ulojs_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              counter_64bit,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              running,
  input  logic [ulojs_pkg::SEC_W-1:0]       sent_seconds,
  input  logic [ulojs_pkg::USEC_W-1:0]      sent_microseconds,
  input  logic [ulojs_pkg::SEQ_W-1:0]       sequence_number,
  input  logic [ulojs_pkg::SEC_W-1:0]       arrival_seconds,
  input  logic [ulojs_pkg::USEC_W-1:0]      arrival_microseconds,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]  queue_level,
  output ulojs_pkg::queue_push_t            push
);
  import ulojs_pkg::*;

  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  logic              v1, run1;
  logic [SEQ_W-1:0]  seq1;
  logic [TIME_W-1:0] sent_us1, arr_us1;

  logic              v2, run2;
  logic [SEQ_W-1:0]  seq2, seqp2;
  logic [TIME_W-1:0] transit2;

  logic              seen;
  logic [TIME_W-1:0] last_transit;

  logic [LW:0]       occupancy;
  logic              accept;
  logic [TIME_W-1:0] prev_used;

  // Space is reserved for every transaction still in the two stages, so the
  // stages never stall and the queue can never overflow.
  assign occupancy = (LW+1)'(queue_level) + (LW+1)'(v1) + (LW+1)'(v2);
  assign in_ready  = occupancy < (LW+1)'(QUEUE_DEPTH);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      seen <= 1'b0;
      last_transit <= '0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      if (v2 && run2) begin
        seen <= 1'b1;
        last_transit <= transit2;
      end
    end
  end

  always_ff @(posedge clk) begin
    run1     <= running;
    seq1     <= counter_64bit ? sequence_number : {32'b0, sequence_number[31:0]};
    sent_us1 <= TIME_W'(sent_seconds) * USEC_PER_SEC + TIME_W'(sent_microseconds);
    arr_us1  <= TIME_W'(arrival_seconds) * USEC_PER_SEC + TIME_W'(arrival_microseconds);

    run2     <= run1;
    seq2     <= seq1;
    seqp2    <= seq1 + SEQ_W'(1);
    transit2 <= (arr_us1 >= sent_us1) ? (arr_us1 - sent_us1) : (sent_us1 - arr_us1);
  end

  // The first running datagram has no predecessor and so no transit change.
  assign prev_used = seen ? last_transit : transit2;

  always_comb begin
    push.valid              = v2;
    push.item.running       = run2;
    push.item.seq           = seq2;
    push.item.seq_plus1     = seqp2;
    push.item.transit_delta = (transit2 >= prev_used) ? (transit2 - prev_used)
                                                      : (prev_used - transit2);
  end

endmodule

>>> src/ulojs_queue.sv
// ============================================================================
// ulojs_queue - small transaction queue between front and back end
// Circular buffer in flip-flops with a fill level for the front end's credit.
// ============================================================================
`timescale 1ns / 1ps

module ulojs_queue #(
  parameter int QUEUE_DEPTH = ulojs_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ulojs_pkg::queue_push_t            push,
  input  logic                              pop,
  output ulojs_pkg::queue_item_t            head,
  output logic                              not_empty,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  level
);
  import ulojs_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  queue_item_t   store [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;

  assign not_empty = level != '0;
  assign head      = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      level <= level + LW'(push.valid) - LW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      store[wr_ptr] <= push.item;
    end
  end

endmodule

>>> src/ulojs_back.sv
// ============================================================================
// ulojs_back - sequence, loss and jitter state update
// Takes one queued classified transaction per cycle unless the result port
// stalls, updating counters and smoothed jitter; state registers are the result.
// ============================================================================
`timescale 1ns / 1ps

module ulojs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ulojs_pkg::queue_item_t        head,
  input  logic                          not_empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ulojs_pkg::CNT_W-1:0]   lost_total,
  output logic [ulojs_pkg::CNT_W-1:0]   out_of_order_total,
  output logic [ulojs_pkg::SEQ_W-1:0]   highest_sequence,
  output logic [ulojs_pkg::JOUT_W-1:0]  jitter_estimate
);
  import ulojs_pkg::*;

  localparam int SUM_W = JIT_W + 5;

  logic [SEQ_W-1:0]  last_seq, next_seq;
  logic [CNT_W-1:0]  lost, ooo;
  logic [JIT_W-1:0]  jitter;

  logic              advance;
  logic [SUM_W-1:0]  jit_sum;

  // Result is taken from the state itself, which only moves on a pop.
  assign pop     = not_empty && (!out_valid || out_ready);
  assign advance = head.seq >= next_seq;
  // 15*J + 16*D, then drop the four low bits
  assign jit_sum = {1'b0, jitter, 4'b0} - SUM_W'(jitter) + SUM_W'({head.transit_delta, 4'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_seq  <= '0;
      next_seq  <= SEQ_W'(1);
      lost      <= '0;
      ooo       <= '0;
      jitter    <= '0;
    end else begin
      out_valid <= pop || (out_valid && !out_ready);
      if (pop && head.running) begin
        if (advance) begin
          lost     <= lost + (head.seq - next_seq);
          last_seq <= head.seq;
          next_seq <= head.seq_plus1;
        end else begin
          ooo <= ooo + CNT_W'(1);
          if (lost != '0) begin
            lost <= lost - CNT_W'(1);
          end
        end
        jitter <= jit_sum[JIT_W+3:4];
      end
    end
  end

  assign lost_total         = lost;
  assign out_of_order_total = ooo;
  assign highest_sequence   = last_seq;
  assign jitter_estimate    = jitter[JOUT_W-1:0];

endmodule

>>> src/udp_loss_order_jitter_stats_unit.sv
// ============================================================================
// udp_loss_order_jitter_stats_unit - receive statistics for test datagrams
// Counts lost and out-of-order datagrams from their sequence numbers and keeps
// an interarrival jitter estimate from sender and arrival timestamps.
// ============================================================================
`timescale 1ns / 1ps

// The unit takes one parsed datagram header per clock cycle while in_ready is
// high and returns one result transaction for every input transaction,
// carrying the loss count, the out-of-order count, the highest sequence
// number seen and the smoothed jitter in microseconds with four fraction
// bits, all as they stand after that datagram. On its way to the result, an
// accepted input passes two front-end stages that convert the timestamps and
// form the transit change, is then written into a short queue, and the back
// end pops it and updates the state. The sustained rate of one transaction
// per cycle, while out_ready stays high, rests on the back end updating the
// state on every pop (the 64-bit sequence compare and loss add, and the
// jitter accumulate) together with a queue deep enough to cover the two
// front-end stages; QUEUE_DEPTH of four or more keeps the full rate.
// Datagrams with running low change nothing but still produce a result.
// Register counter_64bit (address 0) selects whether the full 64-bit
// sequence number or only its low 32 bits are used, and should only be
// written while the unit is idle.

module udp_loss_order_jitter_stats_unit #(
  parameter int QUEUE_DEPTH = ulojs_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ulojs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // input datagram headers
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               running,
  input  logic [ulojs_pkg::SEC_W-1:0]        sent_seconds,
  input  logic [ulojs_pkg::USEC_W-1:0]       sent_microseconds,
  input  logic [ulojs_pkg::SEQ_W-1:0]        sequence_number,
  input  logic [ulojs_pkg::SEC_W-1:0]        arrival_seconds,
  input  logic [ulojs_pkg::USEC_W-1:0]       arrival_microseconds,
  // statistics results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ulojs_pkg::CNT_W-1:0]        lost_total,
  output logic [ulojs_pkg::CNT_W-1:0]        out_of_order_total,
  output logic [ulojs_pkg::SEQ_W-1:0]        highest_sequence,
  output logic [ulojs_pkg::JOUT_W-1:0]       jitter_estimate
);
  import ulojs_pkg::*;

  localparam int LW = $clog2(QUEUE_DEPTH + 1);

  logic          counter_64bit;
  queue_push_t   push;
  queue_item_t   head;
  logic          not_empty;
  logic          pop;
  logic [LW-1:0] queue_level;

  // The APB port never inserts wait states. Only the word index in paddr[2]
  // is decoded; the one register lies at index zero.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_64bit <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_COUNTER_64BIT) begin
      counter_64bit <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_COUNTER_64BIT) begin
      prdata[0] = counter_64bit;
    end
  end

  // Front end: accepts headers while queue space is reserved for them.
  ulojs_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk                  (clk),
    .rst                  (rst),
    .counter_64bit        (counter_64bit),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .running              (running),
    .sent_seconds         (sent_seconds),
    .sent_microseconds    (sent_microseconds),
    .sequence_number      (sequence_number),
    .arrival_seconds      (arrival_seconds),
    .arrival_microseconds (arrival_microseconds),
    .queue_level          (queue_level),
    .push                 (push)
  );

  // Queue decouples the front end from a stalled result port.
  ulojs_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .level     (queue_level)
  );

  // Back end: state update, whose registers double as the result payload.
  ulojs_back u_back (
    .clk                (clk),
    .rst                (rst),
    .head               (head),
    .not_empty          (not_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .lost_total         (lost_total),
    .out_of_order_total (out_of_order_total),
    .highest_sequence   (highest_sequence),
    .jitter_estimate    (jitter_estimate)
  );

`ifndef SYNTH
  // The credit scheme must keep the queue within its depth.
  assert property (@(posedge clk) disable iff (rst)
    queue_level <= LW'(QUEUE_DEPTH))
    else $error("queue level exceeds depth");

  // The back end only takes a transaction from a non-empty queue.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> queue_level != '0)
    else $error("pop from empty queue");

  // A push into a full queue would lose a transaction.
  assert property (@(posedge clk) disable iff (rst)
    (push.valid && !pop) |-> queue_level < LW'(QUEUE_DEPTH))
    else $error("push into full queue");

  // The out-of-order count moves by at most one per cycle.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (out_of_order_total == $past(out_of_order_total) ||
                     out_of_order_total == $past(out_of_order_total) + 64'd1))
    else $error("out-of-order count jumped");
`endif

endmodule
